// ===== hw/rtl/morse_element_tone_generator_top_assert.svh =====
// Assertion macros used by the checker of the Morse element tone generator
`ifndef MORSE_ELEMENT_TONE_GENERATOR_TOP_ASSERT_SVH
`define MORSE_ELEMENT_TONE_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication
`define METG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define METG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/metg_pkg.sv =====
// Package: types, constants and sine table function for the Morse tone generator
`timescale 1ns / 1ps
package metg_pkg;

   localparam int DEF_SINE_TABLE_BITS = 10;
   localparam int DEF_PHASE_BITS      = 32;
   localparam int DEF_SAMPLE_BITS     = 16;

   localparam int QUEUE_DEPTH    = 2;
   localparam int STEP_W         = 32;
   localparam int LEVEL_W        = 15;
   localparam int UNIT_W         = 16;
   localparam int CSR_W          = 32;
   localparam int CSR_IDX_W      = 2;
   localparam int Q15_W          = 15;
   localparam int TONE_LEFT_W    = 18;
   localparam int SILENCE_LEFT_W = 19;
   localparam int MAG_EXT_W      = 25;

   localparam logic [STEP_W-1:0]  STEP_RESET  = 32'd42852281;
   localparam logic [LEVEL_W-1:0] LEVEL_RESET = 15'd16383;
   localparam logic [UNIT_W-1:0]  UNIT_RESET  = 16'd4410;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TONE_STEP    = 2'd0,
      CSR_TONE_LEVEL   = 2'd1,
      CSR_UNIT_SAMPLES = 2'd2
   } csr_index_type;

   typedef enum logic {
      MODE_TICK = 1'b0,
      MODE_LOAD = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      ELEM_DIT        = 2'd0,
      ELEM_DASH       = 2'd1,
      ELEM_LETTER_GAP = 2'd2,
      ELEM_WORD_GAP   = 2'd3
   } element_type;

   typedef struct packed {
      logic is_sample;
      logic tone;
      logic done;
      logic busy;
      logic refused;
   } flags_type;

   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
   localparam logic [63:0] TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

   // Q15 sin(pi/2 * r / 2^qbits), Taylor series in Q30, rounded and capped
   function automatic logic [Q15_W-1:0] quarter_sine(input int unsigned r,
                                                     input int unsigned qbits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic signed [64:0] sum;
      logic [64:0] q;
      x    = (PI_HALF_Q30 * 64'(r)) >> qbits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed({1'b0, x});
      for (int k = 0; k < 6; k++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[k];
         if ((k % 2) == 0) sum = sum - $signed({1'b0, term});
         else              sum = sum + $signed({1'b0, term});
      end
      if (sum < 0) sum = '0;
      q = (65'(sum) + 65'd16384) >> 15;
      if (q > 65'd32767) q = 65'd32767;
      return q[Q15_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/metg_req_if.sv =====
// Request channel interface: mode and element beats
`timescale 1ns / 1ps
interface metg_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [1:0] element;

   modport source (output valid, output mode, output element, input ready);
   modport sink   (input valid, input mode, input element, output ready);
endinterface

// ===== hw/rtl/metg_rsp_if.sv =====
// Response channel interface: sample and status beats
`timescale 1ns / 1ps
interface metg_rsp_if #(parameter int SAMPLE_BITS = metg_pkg::DEF_SAMPLE_BITS);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          is_sample;
   logic                          element_done;
   logic                          busy_res;
   logic                          refused;

   modport source (output valid, output sample, output is_sample, output element_done,
                   output busy_res, output refused, input ready);
   modport sink   (input valid, input sample, input is_sample, input element_done,
                   input busy_res, input refused, output ready);
endinterface

// ===== hw/rtl/metg_queue.sv =====
// Small command queue between the sequencer and the sample pipeline
`timescale 1ns / 1ps
module metg_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = metg_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              not_empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [AW:0]       count_ff, count_in;

   assign full      = (count_ff == (AW+1)'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// ===== hw/rtl/metg_front.sv =====
// Element sequencer: takes request beats, tracks tone/silence counts and phase
`timescale 1ns / 1ps
module metg_front #(
   parameter int SINE_TABLE_BITS = metg_pkg::DEF_SINE_TABLE_BITS,
   parameter int PHASE_BITS      = metg_pkg::DEF_PHASE_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_mode,
   input  logic [1:0]                       req_element,
   input  logic [metg_pkg::STEP_W-1:0]      tone_step,
   input  logic [metg_pkg::UNIT_W-1:0]      unit_samples,
   output logic                             push,
   output metg_pkg::flags_type              push_flags,
   output logic [SINE_TABLE_BITS-1:0]       push_index,
   input  logic                             queue_full
);
   localparam int TLW = metg_pkg::TONE_LEFT_W;
   localparam int SLW = metg_pkg::SILENCE_LEFT_W;
   localparam int UW  = metg_pkg::UNIT_W;

   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [TLW-1:0]        tone_left_ff, tone_left_in;
   logic [SLW-1:0]        silence_left_ff, silence_left_in;
   logic                  active_ff, active_in;

   logic                  accept;
   logic [UW-1:0]         unit_eff;
   logic [TLW-1:0]        unit_x3;
   logic [SLW-1:0]        unit_x7;

   assign accept     = req_valid && !queue_full;
   assign req_ready  = !queue_full;
   assign push       = accept;
   assign push_index = phase_ff[PHASE_BITS-1 -: SINE_TABLE_BITS];

   assign unit_eff = (unit_samples == '0) ? UW'(1) : unit_samples;
   assign unit_x3  = TLW'(unit_eff) + {1'b0, unit_eff, 1'b0};
   assign unit_x7  = {unit_eff, 3'b000} - SLW'(unit_eff);

   always_comb begin
      phase_in        = phase_ff;
      tone_left_in    = tone_left_ff;
      silence_left_in = silence_left_ff;
      active_in       = active_ff;
      push_flags      = '0;
      if (accept) begin
         if (req_mode == metg_pkg::MODE_LOAD) begin
            if (active_ff) begin
               push_flags.refused = 1'b1;
               push_flags.busy    = 1'b1;
            end else begin
               unique case (metg_pkg::element_type'(req_element))
                  metg_pkg::ELEM_DIT: begin
                     tone_left_in    = TLW'(unit_eff);
                     silence_left_in = SLW'(unit_eff);
                     phase_in        = '0;
                  end
                  metg_pkg::ELEM_DASH: begin
                     tone_left_in    = unit_x3;
                     silence_left_in = SLW'(unit_eff);
                     phase_in        = '0;
                  end
                  metg_pkg::ELEM_LETTER_GAP: begin
                     tone_left_in    = '0;
                     silence_left_in = SLW'(unit_x3);
                  end
                  metg_pkg::ELEM_WORD_GAP: begin
                     tone_left_in    = '0;
                     silence_left_in = unit_x7;
                  end
               endcase
               active_in       = 1'b1;
               push_flags.busy = 1'b1;
            end
         end else begin
            push_flags.is_sample = 1'b1;
            if (active_ff) begin
               if (tone_left_ff != '0) begin
                  push_flags.tone = 1'b1;
                  phase_in        = phase_ff + PHASE_BITS'(tone_step);
                  tone_left_in    = tone_left_ff - TLW'(1);
               end else if (silence_left_ff != '0) begin
                  silence_left_in = silence_left_ff - SLW'(1);
               end
               if (tone_left_in == '0 && silence_left_in == '0) begin
                  push_flags.done = 1'b1;
                  active_in       = 1'b0;
               end
               push_flags.busy = active_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= '0;
         tone_left_ff    <= '0;
         silence_left_ff <= '0;
         active_ff       <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         tone_left_ff    <= tone_left_in;
         silence_left_ff <= silence_left_in;
         active_ff       <= active_in;
      end
   end
endmodule

// ===== hw/rtl/metg_back.sv =====
// Sample pipeline: quarter-wave sine lookup, level scaling, saturation, output register
`timescale 1ns / 1ps
module metg_back #(
   parameter int SINE_TABLE_BITS = metg_pkg::DEF_SINE_TABLE_BITS,
   parameter int SAMPLE_BITS     = metg_pkg::DEF_SAMPLE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  metg_pkg::flags_type               q_flags,
   input  logic [SINE_TABLE_BITS-1:0]        q_index,
   output logic                              q_pop,
   input  logic [metg_pkg::LEVEL_W-1:0]      tone_level,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]     rsp_sample,
   output metg_pkg::flags_type               rsp_flags
);
   localparam int QB  = SINE_TABLE_BITS - 2;
   localparam int QS  = 1 << QB;
   localparam int QAW = QB + 1;
   localparam int QW  = metg_pkg::Q15_W;
   localparam int LW  = metg_pkg::LEVEL_W;
   localparam int PW  = LW + QW;
   localparam int EW  = metg_pkg::MAG_EXT_W;
   localparam logic [EW-1:0] SAMPLE_MAX = EW'((1 << (SAMPLE_BITS - 1)) - 1);

   logic [QW-1:0] qtab [QS+1];

   for (genvar gi = 0; gi <= QS; gi++) begin : g_qtab
      localparam logic [QW-1:0] QVAL = metg_pkg::quarter_sine(gi, QB);
      assign qtab[gi] = QVAL;
   end

   // lookup stage
   logic                  a_valid_ff;
   metg_pkg::flags_type   a_flags_ff;
   logic [QW-1:0]         a_mag_ff;
   logic                  a_neg_ff;

   // output stage
   logic                  o_valid_ff;
   metg_pkg::flags_type   o_flags_ff;
   logic signed [SAMPLE_BITS-1:0] o_sample_ff, o_sample_in;

   logic                  out_free, a_free;
   logic [1:0]            quad;
   logic [QB-1:0]         qoff;
   logic [QAW-1:0]        qaddr;
   logic [PW-1:0]         product;
   logic [EW-1:0]         mag_ext, mag_clip;

   assign out_free = !o_valid_ff || rsp_ready;
   assign a_free   = !a_valid_ff || out_free;
   assign q_pop    = q_valid && a_free;

   assign quad  = q_index[SINE_TABLE_BITS-1 -: 2];
   assign qoff  = q_index[QB-1:0];
   assign qaddr = quad[0] ? (QAW'(QS) - QAW'(qoff)) : QAW'(qoff);

   always_comb begin
      product  = PW'(tone_level) * PW'(a_mag_ff);
      mag_ext  = EW'(product[PW-1:QW]);
      mag_clip = (mag_ext > SAMPLE_MAX) ? SAMPLE_MAX : mag_ext;
      if (a_neg_ff) o_sample_in = SAMPLE_BITS'(0) - SAMPLE_BITS'(mag_clip);
      else          o_sample_in = SAMPLE_BITS'(mag_clip);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (a_free) a_valid_ff <= q_valid;
         if (out_free) o_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_free) begin
         a_flags_ff <= q_flags;
         a_mag_ff   <= q_flags.tone ? qtab[qaddr] : '0;
         a_neg_ff   <= quad[1];
      end
      if (out_free) begin
         o_flags_ff  <= a_flags_ff;
         o_sample_ff <= o_sample_in;
      end
   end

   assign rsp_valid  = o_valid_ff;
   assign rsp_sample = o_sample_ff;
   assign rsp_flags  = o_flags_ff;
endmodule

// ===== hw/rtl/morse_element_tone_generator_top.sv =====
// Top level of the Morse element tone generator
// Accepts one request beat per clock while the response side keeps up; every beat
// gives exactly one response beat after passing the command queue, the sine lookup
// stage and the scaling stage with its output register. The element sequencer and the
// sample pipeline are split by a two-entry command queue, so request acceptance
// stalls only when that queue is full. A load beat while an element is in
// progress is dropped and answered with refused set. unit_samples is latched at
// load; tone_step and tone_level are read live. CSR writes take effect next clock.
`timescale 1ns / 1ps
module morse_element_tone_generator_top #(
   parameter int SINE_TABLE_BITS = metg_pkg::DEF_SINE_TABLE_BITS,
   parameter int PHASE_BITS      = metg_pkg::DEF_PHASE_BITS,
   parameter int SAMPLE_BITS     = metg_pkg::DEF_SAMPLE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   metg_req_if.sink                          req_bus,
   metg_rsp_if.source                        rsp_bus,
   input  logic                              csr_we,
   input  logic [metg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [metg_pkg::CSR_W-1:0]        csr_wdata
);
   localparam int QDW = $bits(metg_pkg::flags_type) + SINE_TABLE_BITS;

   logic [metg_pkg::STEP_W-1:0]  tone_step_ff;
   logic [metg_pkg::LEVEL_W-1:0] tone_level_ff;
   logic [metg_pkg::UNIT_W-1:0]  unit_samples_ff;

   logic                         push, pop, q_full, q_not_empty;
   metg_pkg::flags_type          push_flags, pop_flags, rsp_flags;
   logic [SINE_TABLE_BITS-1:0]   push_index, pop_index;
   logic [QDW-1:0]               pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_step_ff    <= metg_pkg::STEP_RESET;
         tone_level_ff   <= metg_pkg::LEVEL_RESET;
         unit_samples_ff <= metg_pkg::UNIT_RESET;
      end else if (csr_we) begin
         if (csr_index == metg_pkg::CSR_TONE_STEP)
            tone_step_ff <= csr_wdata[metg_pkg::STEP_W-1:0];
         if (csr_index == metg_pkg::CSR_TONE_LEVEL)
            tone_level_ff <= csr_wdata[metg_pkg::LEVEL_W-1:0];
         if (csr_index == metg_pkg::CSR_UNIT_SAMPLES)
            unit_samples_ff <= csr_wdata[metg_pkg::UNIT_W-1:0];
      end
   end

   metg_front #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .PHASE_BITS      (PHASE_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_bus.valid),
      .req_ready    (req_bus.ready),
      .req_mode     (req_bus.mode),
      .req_element  (req_bus.element),
      .tone_step    (tone_step_ff),
      .unit_samples (unit_samples_ff),
      .push         (push),
      .push_flags   (push_flags),
      .push_index   (push_index),
      .queue_full   (q_full)
   );

   metg_queue #(
      .DATA_W (QDW),
      .DEPTH  (metg_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_flags, push_index}),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (q_not_empty)
   );

   assign pop_flags = metg_pkg::flags_type'(pop_data[QDW-1:SINE_TABLE_BITS]);
   assign pop_index = pop_data[SINE_TABLE_BITS-1:0];

   metg_back #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_not_empty),
      .q_flags    (pop_flags),
      .q_index    (pop_index),
      .q_pop      (pop),
      .tone_level (tone_level_ff),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .rsp_sample (rsp_bus.sample),
      .rsp_flags  (rsp_flags)
   );

   assign rsp_bus.is_sample    = rsp_flags.is_sample;
   assign rsp_bus.element_done = rsp_flags.done;
   assign rsp_bus.busy_res     = rsp_flags.busy;
   assign rsp_bus.refused      = rsp_flags.refused;
endmodule

// ===== hw/rtl/metg_checker.sv =====
// Port-level checker for the Morse element tone generator, bound to the top level
`timescale 1ns / 1ps
`include "morse_element_tone_generator_top_assert.svh"
module metg_checker #(
   parameter int SAMPLE_BITS = metg_pkg::DEF_SAMPLE_BITS
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [SAMPLE_BITS-1:0] rsp_sample,
   input logic                          is_sample,
   input logic                          element_done,
   input logic                          busy_res,
   input logic                          refused
);
   `METG_ASSERT_SAME(a_refused_beat, clock, reset, rsp_valid && refused, busy_res && !is_sample && !element_done && (rsp_sample == '0), "refused beat must be a silent busy load answer")
   `METG_ASSERT_SAME(a_done_beat, clock, reset, rsp_valid && element_done, is_sample && !busy_res && !refused, "element end must be a tick answer that leaves the block idle")
   `METG_ASSERT_SAME(a_load_silent, clock, reset, rsp_valid && !is_sample, (rsp_sample == '0), "load answer must carry a zero sample")
   `METG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sample) && $stable(is_sample) && $stable(busy_res), "stalled response beat changed")
endmodule

bind morse_element_tone_generator_top metg_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_metg_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_sample   (rsp_bus.sample),
   .is_sample    (rsp_bus.is_sample),
   .element_done (rsp_bus.element_done),
   .busy_res     (rsp_bus.busy_res),
   .refused      (rsp_bus.refused)
);

// ===== tb/sv/metg_response_check.sv =====
// Response checker for the Morse element tone generator: predicts and compares beats
`timescale 1ns / 1ps
module metg_response_check (
   input  logic                             clock,
   input  logic                             reset,
   metg_req_if                              req_mon,
   metg_rsp_if                              rsp_mon,
   input  logic                             csr_we,
   input  logic [metg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [metg_pkg::CSR_W-1:0]       csr_wdata,
   output int                               fail_count,
   output int                               pending,
   output int                               completed,
   output int                               refusals,
   output int                               tone_samples
);
   import metg_pkg::*;

   localparam int TABLE_BITS = 10;
   localparam int QTR_BITS   = TABLE_BITS - 2;
   localparam int QTR_SIZE   = 1 << QTR_BITS;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               is_sample;
      logic               element_done;
      logic               busy_res;
      logic               refused;
   } tone_beat_type;

   logic [14:0]   sine_q15 [QTR_SIZE+1];
   logic [31:0]   step_reg;
   logic [14:0]   level_reg;
   logic [15:0]   unit_reg;
   logic [31:0]   phase_acc;
   logic [17:0]   tone_remaining;
   logic [18:0]   gap_remaining;
   logic          element_active;
   tone_beat_type awaited_beats [$];
   int            mismatches;
   int            done_count;
   int            refused_count;
   int            nonzero_count;

   // quarter-wave sine in Q15 from a Q30 Taylor series
   function automatic logic [14:0] q15_quarter_sine(input int unsigned r);
      logic [63:0] angle;
      logic [63:0] angle_sq;
      logic [63:0] term;
      logic [63:0] q;
      longint      acc;
      angle    = (HALF_PI_Q30 * 64'(r)) >> QTR_BITS;
      angle_sq = (angle * angle) >> 30;
      term     = angle;
      acc      = $signed(angle);
      for (int n = 1; n <= 6; n++) begin
         term = ((term * angle_sq) >> 30) / 64'(2 * n * (2 * n + 1));
         if (n % 2) acc = acc - $signed(term);
         else       acc = acc + $signed(term);
      end
      if (acc < 0) acc = 0;
      q = ($unsigned(acc) + 64'd16384) >> 15;
      return (q > 64'd32767) ? 15'h7FFF : q[14:0];
   endfunction

   initial begin
      for (int i = 0; i <= QTR_SIZE; i++) sine_q15[i] = q15_quarter_sine(i);
   end

   function automatic logic signed [15:0] tone_value();
      logic [TABLE_BITS-1:0] idx;
      logic [14:0]           mag_q15;
      logic [29:0]           prod;
      logic [15:0]           mag;
      idx     = phase_acc[31 -: TABLE_BITS];
      mag_q15 = idx[QTR_BITS] ? sine_q15[QTR_SIZE - idx[QTR_BITS-1:0]]
                              : sine_q15[idx[QTR_BITS-1:0]];
      prod    = level_reg * mag_q15;
      mag     = {1'b0, prod[29:15]};
      return idx[TABLE_BITS-1] ? -$signed(mag) : $signed(mag);
   endfunction

   // one request beat through the keyer state, giving the response it must cause
   function automatic tone_beat_type advance_keyer(input logic kind, input logic [1:0] elem);
      tone_beat_type r;
      logic [15:0]   unit;
      r    = '0;
      unit = (unit_reg == 16'd0) ? 16'd1 : unit_reg;
      if (kind == MODE_LOAD) begin
         if (element_active) begin
            r.refused = 1'b1;
         end else begin
            case (elem)
               ELEM_DIT: begin
                  tone_remaining = 18'(unit);
                  gap_remaining  = 19'(unit);
               end
               ELEM_DASH: begin
                  tone_remaining = 18'(unit) * 18'd3;
                  gap_remaining  = 19'(unit);
               end
               ELEM_LETTER_GAP: begin
                  tone_remaining = '0;
                  gap_remaining  = 19'(unit) * 19'd3;
               end
               default: begin
                  tone_remaining = '0;
                  gap_remaining  = 19'(unit) * 19'd7;
               end
            endcase
            if (elem == ELEM_DIT || elem == ELEM_DASH) phase_acc = '0;
            element_active = 1'b1;
         end
      end else begin
         r.is_sample = 1'b1;
         if (element_active) begin
            if (tone_remaining != '0) begin
               r.sample       = tone_value();
               phase_acc      = phase_acc + step_reg;
               tone_remaining = tone_remaining - 18'd1;
            end else if (gap_remaining != '0) begin
               gap_remaining = gap_remaining - 19'd1;
            end
            if (tone_remaining == '0 && gap_remaining == '0) begin
               r.element_done = 1'b1;
               element_active = 1'b0;
            end
         end
      end
      r.busy_res = element_active;
      return r;
   endfunction

   task automatic compare_field(input string name, input logic signed [16:0] want,
                                input logic signed [16:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_beat();
      tone_beat_type want;
      if (awaited_beats.size() == 0) begin
         $display("%0t: response beat with none awaited, expected none, got sample %0d",
                  $time, rsp_mon.sample);
         mismatches++;
      end else begin
         want = awaited_beats.pop_front();
         compare_field("sample", $signed(want.sample), rsp_mon.sample);
         compare_field("is_sample", want.is_sample, rsp_mon.is_sample);
         compare_field("element_done", want.element_done, rsp_mon.element_done);
         compare_field("busy_res", want.busy_res, rsp_mon.busy_res);
         compare_field("refused", want.refused, rsp_mon.refused);
         if (want.element_done) done_count++;
         if (want.refused) refused_count++;
         if (want.sample != 16'sd0) nonzero_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         step_reg       = STEP_RESET;
         level_reg      = LEVEL_RESET;
         unit_reg       = UNIT_RESET;
         phase_acc      = '0;
         tone_remaining = '0;
         gap_remaining  = '0;
         element_active = 1'b0;
         awaited_beats.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) check_beat();
         if (req_mon.valid && req_mon.ready)
            awaited_beats.push_back(advance_keyer(req_mon.mode, req_mon.element));
         // register writes are seen from the next beat on
         if (csr_we) begin
            case (csr_index)
               CSR_TONE_STEP:    step_reg  = csr_wdata[STEP_W-1:0];
               CSR_TONE_LEVEL:   level_reg = csr_wdata[LEVEL_W-1:0];
               CSR_UNIT_SAMPLES: unit_reg  = csr_wdata[UNIT_W-1:0];
               default: ;
            endcase
         end
      end
      pending      <= awaited_beats.size();
      fail_count   <= mismatches;
      completed    <= done_count;
      refusals     <= refused_count;
      tone_samples <= nonzero_count;
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the Morse element tone generator: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_top;
   import metg_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int STALL_LIMIT  = 2000;
   localparam int ITEMS_PER_SET = 210;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   int          send_idle_pct;
   int          recv_idle_pct;
   logic [15:0] unit_now;
   int          elem_left;
   int          loads_sent;
   int          ticks_sent;

   int fail_count;
   int pending;
   int completed;
   int refusals;
   int tone_samples;

   metg_req_if req_bus ();
   metg_rsp_if rsp_bus ();

   morse_element_tone_generator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   metg_response_check response_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .pending      (pending),
      .completed    (completed),
      .refusals     (refusals),
      .tone_samples (tone_samples)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else       rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_beat(input mode_type kind, input element_type elem);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.mode    <= kind;
      req_bus.element <= elem;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (kind == MODE_LOAD) loads_sent++;
      else                   ticks_sent++;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // upper data bits are noise the block must mask off
   task automatic program_regs(input logic [31:0] incr, input logic [14:0] level,
                               input logic [15:0] unit);
      write_reg(CSR_TONE_STEP, incr);
      write_reg(CSR_TONE_LEVEL, {17'($urandom), level});
      write_reg(CSR_UNIT_SAMPLES, {16'($urandom), unit});
      write_reg(CSR_SPARE, $urandom);
      csr_we   <= 1'b0;
      unit_now = unit;
   endtask

   task automatic program_random();
      logic [31:0] incr;
      logic [14:0] level;
      case ($urandom_range(3))
         0: incr = '0;
         1: incr = '1;
         2: incr = 32'h8000_0000 >> $urandom_range(16);
         default: incr = $urandom;
      endcase
      level = ($urandom_range(3) == 0) ? 15'h7FFF : 15'($urandom);
      program_regs(incr, level, 16'($urandom_range(6)));
   endtask

   function automatic int element_ticks(input element_type elem);
      int u;
      u = (unit_now == 16'd0) ? 1 : int'(unit_now);
      case (elem)
         ELEM_DIT:        return 2 * u;
         ELEM_DASH:       return 4 * u;
         ELEM_LETTER_GAP: return 3 * u;
         default:         return 7 * u;
      endcase
   endfunction

   // mostly whole elements ticked out, with idle ticks and loads into a busy keyer
   task automatic next_item();
      element_type elem;
      elem = element_type'($urandom_range(3));
      if (elem_left == 0) begin
         if ($urandom_range(9) < 7) begin
            send_beat(MODE_LOAD, elem);
            elem_left = element_ticks(elem);
         end else begin
            send_beat(MODE_TICK, elem);
         end
      end else if ($urandom_range(24) == 0) begin
         send_beat(MODE_LOAD, elem);
      end else begin
         send_beat(MODE_TICK, elem);
         elem_left--;
      end
   endtask

   task automatic finish_element();
      while (elem_left > 0) begin
         send_beat(MODE_TICK, element_type'($urandom_range(3)));
         elem_left--;
      end
   endtask

   initial begin
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_index       <= CSR_TONE_STEP;
      csr_wdata       <= '0;
      req_bus.valid   <= 1'b0;
      req_bus.mode    <= MODE_TICK;
      req_bus.element <= ELEM_DIT;
      unit_now        = UNIT_RESET;
      elem_left       = 0;
      loads_sent      = 0;
      ticks_sent      = 0;
      send_idle_pct   = 7;
      recv_idle_pct   = 45;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: idle tick, every element at unit 1, refused loads, quadrant edges
      send_beat(MODE_TICK, ELEM_WORD_GAP);
      wait_drained();
      program_regs(32'h4000_0000, 15'h7FFF, 16'd1);
      send_beat(MODE_LOAD, ELEM_DIT);
      send_beat(MODE_LOAD, ELEM_DASH);
      repeat (2) send_beat(MODE_TICK, ELEM_DIT);
      send_beat(MODE_LOAD, ELEM_DASH);
      repeat (4) send_beat(MODE_TICK, ELEM_LETTER_GAP);
      send_beat(MODE_LOAD, ELEM_LETTER_GAP);
      send_beat(MODE_LOAD, ELEM_WORD_GAP);
      repeat (3) send_beat(MODE_TICK, ELEM_DASH);
      send_beat(MODE_LOAD, ELEM_WORD_GAP);
      send_beat(MODE_LOAD, ELEM_DIT);
      repeat (8) send_beat(MODE_TICK, ELEM_WORD_GAP);
      wait_drained();

      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 7 : (p == 1) ? 45 : 0;
         recv_idle_pct = (p == 0) ? 45 : (p == 1) ? 7 : 0;
         for (int s = 0; s < 3; s++) begin
            if (s != 0)      program_random();
            else if (p == 0) program_regs('1, 15'h7FFF, 16'd1);
            else if (p == 1) program_regs('0, '0, '0);
            else             program_regs(32'h8000_0000, 15'h7FFF, 16'd2);
            repeat (ITEMS_PER_SET) next_item();
            wait_drained();
         end
      end

      // start of a dash at the longest unit, with a load refused partway in
      finish_element();
      wait_drained();
      program_regs($urandom, 15'h7FFF, 16'hFFFF);
      send_beat(MODE_LOAD, ELEM_DASH);
      repeat (24) send_beat(MODE_TICK, ELEM_DIT);
      send_beat(MODE_LOAD, ELEM_WORD_GAP);
      repeat (4) send_beat(MODE_TICK, ELEM_DIT);
      wait_drained();
      repeat (16) @(posedge clock);

      $display("Sent %0d loads and %0d ticks; %0d loads refused, %0d elements completed.",
               loads_sent, ticks_sent, refusals, completed);
      $display("%0d nonzero tone samples; step, level and unit taken to both extremes.",
               tone_samples);
      if (fail_count == 0) $display("Simulation PASSED");
      else                 $display("Simulation FAILED");
      $finish;
   end

   initial begin : watchdog
      int stall;
      stall = 0;
      while (stall < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) stall = 0;
         else stall++;
      end
      $display("Simulation FAILED");
      $finish;
   end

endmodule
